[src/legged_foot_placement_top_assert.svh]
// Assertion macros for the foot placement block
`ifndef LEGGED_FOOT_PLACEMENT_TOP_ASSERT_SVH
`define LEGGED_FOOT_PLACEMENT_TOP_ASSERT_SVH
// Check that a condition implies a consequence on the next edge
`define LFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Check that a condition holds at every edge out of reset
`define LFP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

[src/lfp_pkg.sv]
// Types and constants shared by the foot placement block
package lfp_pkg;
  localparam int unsigned CORDIC_N = 17;
  localparam logic signed [22:0] ANG_2PI = 23'sd411775;
  localparam logic signed [22:0] ANG_PI  = 23'sd205887;
  localparam logic signed [22:0] ANG_PI2 = 23'sd102944;
  localparam logic [15:0] CORDIC_K = 16'd39797;

  localparam logic [2:0] REG_GAIT   = 3'd0;
  localparam logic [2:0] REG_GAINS  = 3'd1;
  localparam logic [2:0] REG_LEG0   = 3'd2;

  typedef struct packed {
    logic [1:0]         leg_index;
    logic signed [15:0] body_vel_x;
    logic signed [15:0] body_vel_y;
    logic signed [15:0] goal_vel_x;
    logic signed [15:0] goal_vel_y;
    logic signed [15:0] body_yaw;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] goal_yaw_rate;
    logic [15:0]        gait_phase;
    logic signed [31:0] body_pos_x;
    logic signed [31:0] body_pos_y;
  } lfp_in_t;

  typedef struct packed {
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
  } lfp_out_t;

  // Step predictor output with passthrough for the later stages
  typedef struct packed {
    logic signed [63:0] step_x;
    logic signed [63:0] step_y;
    logic signed [22:0] ang;
    logic               flip;
    logic [15:0]        radius;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } lfp_step_t;

  function automatic logic [15:0] atan_q16(input int unsigned i);
    logic [15:0] a;
    case (i)
      0: a = 16'd51472;
      1: a = 16'd30386;
      2: a = 16'd16055;
      3: a = 16'd8150;
      4: a = 16'd4091;
      5: a = 16'd2047;
      default: a = 16'(32'd1 << (16 - i));
    endcase
    return a;
  endfunction
endpackage

[src/lfp_step.sv]
// Step prediction and angle reduction pipeline
module lfp_step import lfp_pkg::*; #(
  parameter int NUM_LEGS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  lfp_in_t          in_beat,
  input  logic [31:0]      gait_timing,
  input  logic [47:0]      gains,
  input  logic [31:0]      geom [NUM_LEGS],
  output logic             out_valid,
  output lfp_step_t        out_beat
);
  // floor(2^32 / 2*pi in Q16), used to estimate the turn count
  localparam logic signed [40:0] ANG_RECIP = 41'sd10430;

  // stage 1: f*Ts, half stance, errors, leg lookup
  logic               v1;
  logic signed [33:0] fts1;
  logic signed [17:0] hst1;
  logic signed [15:0] vx1, vy1, w1;
  logic signed [16:0] ex1, ey1, ew1;
  logic [15:0]        kx1, ky1, kw1, rad1;
  logic signed [22:0] base1;
  logic signed [31:0] px1, py1;
  // stage 2: products
  logic               v2;
  logic signed [63:0] ax2, ay2, aw2, bx2, by2, bw2;
  logic signed [22:0] base2;
  logic [15:0]        rad2;
  logic signed [31:0] px2, py2;
  // stage 3: sums
  logic               v3;
  logic signed [63:0] sx3, sy3;
  logic signed [25:0] ang3;
  logic [15:0]        rad3;
  logic signed [31:0] px3, py3;
  // stage 4: wrap
  logic               v4;
  logic signed [63:0] sx4, sy4;
  logic signed [22:0] ang4;
  logic [15:0]        rad4;
  logic signed [31:0] px4, py4;

  logic [16:0]        f;
  logic [15:0]        mnt;
  logic [15:0]        rsel;
  logic signed [63:0] syaw;
  logic signed [63:0] rnd;
  logic signed [25:0] ang_sum, ang_m;
  logic signed [40:0] qp;
  logic signed [8:0]  q;
  logic signed [22:0] ang_w;

  always_comb begin
    f = 17'h10000 - {1'b0, in_beat.gait_phase};
    rsel = '0;
    mnt = '0;
    for (int i = 0; i < NUM_LEGS; i++) begin
      if (32'(in_beat.leg_index) == i) begin
        rsel = geom[i][15:0];
        mnt = geom[i][31:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    fts1 <= $signed({1'b0, 33'(f) * 33'(gait_timing[15:0])});
    hst1 <= $signed({2'b0, gait_timing[31:16]});
    vx1 <= in_beat.body_vel_x;
    vy1 <= in_beat.body_vel_y;
    w1 <= in_beat.yaw_rate;
    ex1 <= 17'(in_beat.body_vel_x) - 17'(in_beat.goal_vel_x);
    ey1 <= 17'(in_beat.body_vel_y) - 17'(in_beat.goal_vel_y);
    ew1 <= 17'(in_beat.goal_yaw_rate) - 17'(in_beat.yaw_rate);
    kx1 <= gains[15:0];
    ky1 <= gains[31:16];
    kw1 <= gains[47:32];
    rad1 <= rsel;
    base1 <= 23'(in_beat.body_yaw) * 23'sd8 + 23'($signed(mnt)) * 23'sd8;
    px1 <= in_beat.body_pos_x;
    py1 <= in_beat.body_pos_y;

    ax2 <= 64'(vx1) * 64'(fts1) + 64'(vx1) * 64'(hst1) * 64'sd32768;
    ay2 <= 64'(vy1) * 64'(fts1) + 64'(vy1) * 64'(hst1) * 64'sd32768;
    aw2 <= 64'(w1) * 64'(fts1) + 64'(w1) * 64'(hst1) * 64'sd32768;
    bx2 <= 64'(ex1) * $signed({48'd0, kx1}) * 64'sd4096;
    by2 <= 64'(ey1) * $signed({48'd0, ky1}) * 64'sd4096;
    bw2 <= 64'(ew1) * $signed({48'd0, kw1}) * 64'sd4096;
    base2 <= base1;
    rad2 <= rad1;
    px2 <= px1;
    py2 <= py1;

    sx3 <= ax2 + bx2;
    sy3 <= ay2 + by2;
    ang3 <= ang_sum;
    rad3 <= rad2;
    px3 <= px2;
    py3 <= py2;

    sx4 <= sx3;
    sy4 <= sy3;
    ang4 <= ang_w;
    rad4 <= rad3;
    px4 <= px3;
    py4 <= py3;
  end

  always_comb begin
    syaw = aw2 + bw2;
    rnd = (syaw + 64'sd8388608) >>> 24;
    ang_sum = 26'(rnd) + 26'(base2);
    // nearest turn count, then remove whole turns
    qp = 41'(ang3) * ANG_RECIP + 41'sd2147483648;
    q = 9'(qp >>> 32);
    ang_m = ang3 - 26'(q) * 26'(ANG_2PI);
    if (ang_m > 26'(ANG_PI)) begin
      ang_w = 23'(ang_m - 26'(ANG_2PI));
    end else if (ang_m < -26'(ANG_PI)) begin
      ang_w = 23'(ang_m + 26'(ANG_2PI));
    end else begin
      ang_w = 23'(ang_m);
    end
  end

  always_comb begin
    out_valid = v4;
    out_beat.step_x = sx4;
    out_beat.step_y = sy4;
    out_beat.radius = rad4;
    out_beat.pos_x = px4;
    out_beat.pos_y = py4;
    if (ang4 > ANG_PI2) begin
      out_beat.ang = ang4 - ANG_PI;
      out_beat.flip = 1'b1;
    end else if (ang4 < -ANG_PI2) begin
      out_beat.ang = ang4 + ANG_PI;
      out_beat.flip = 1'b1;
    end else begin
      out_beat.ang = ang4;
      out_beat.flip = 1'b0;
    end
  end
endmodule

[src/lfp_cordic.sv]
// Pipelined CORDIC rotation and final sum with saturation
module lfp_cordic import lfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  lfp_step_t  in_beat,
  output logic       out_valid,
  output lfp_out_t   out_beat
);
  logic               vs [CORDIC_N+1];
  logic signed [33:0] cx [CORDIC_N+1];
  logic signed [33:0] cy [CORDIC_N+1];
  logic signed [22:0] z  [CORDIC_N+1];
  lfp_step_t          pl [CORDIC_N+1];
  logic               vf;
  logic signed [63:0] tx, ty;
  logic signed [63:0] rx, ry;
  logic signed [33:0] fx, fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
    cx[0] <= 34'({1'b0, in_beat.radius}) * 34'({1'b0, CORDIC_K});
    cy[0] <= '0;
    z[0] <= in_beat.ang;
    pl[0] <= in_beat;
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
      if (z[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        z[i+1] <= z[i] - $signed({7'd0, atan_q16(i)});
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        z[i+1] <= z[i] + $signed({7'd0, atan_q16(i)});
      end
      pl[i+1] <= pl[i];
    end
  end

  always_comb begin
    fx = pl[CORDIC_N].flip ? -cx[CORDIC_N] : cx[CORDIC_N];
    fy = pl[CORDIC_N].flip ? -cy[CORDIC_N] : cy[CORDIC_N];
    rx = (tx + 64'sd8388608) >>> 24;
    ry = (ty + 64'sd8388608) >>> 24;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vf <= vs[CORDIC_N];
      out_valid <= vf;
    end
    tx <= (64'(pl[CORDIC_N].pos_x) <<< 24) + pl[CORDIC_N].step_x + (64'(fx) <<< 10);
    ty <= (64'(pl[CORDIC_N].pos_y) <<< 24) + pl[CORDIC_N].step_y + (64'(fy) <<< 10);
    if (rx > 64'sd2147483647) begin
      out_beat.foot_x <= 32'h7fffffff;
    end else if (rx < -64'sd2147483648) begin
      out_beat.foot_x <= 32'h80000000;
    end else begin
      out_beat.foot_x <= 32'(rx);
    end
    if (ry > 64'sd2147483647) begin
      out_beat.foot_y <= 32'h7fffffff;
    end else if (ry < -64'sd2147483648) begin
      out_beat.foot_y <= 32'h80000000;
    end else begin
      out_beat.foot_y <= 32'(ry);
    end
  end
endmodule

[src/legged_foot_placement_top.sv]
// Top level of the foot placement block
// Usage: pulse start with one beat on item; busy is always low, so a beat
// can enter on every cycle. Each beat gives one result on result, marked by
// done for exactly one cycle; the receiver cannot stall and must take it.
// Path: a beat passes through the four step stages, the 18-stage CORDIC
// rotator and two sum stages before done rises with its result.
// Throughput: one beat per cycle.
// Configuration: cfg_we, cfg_index, cfg_data write register cfg_index at a
// rising edge; write only while no beat is in flight. Indexes above 5 are
// ignored.
// Reset (rst, synchronous): clears all beats in flight and restores the
// register defaults.
// Results come in input order with no gaps or repeats.
module legged_foot_placement_top import lfp_pkg::*; #(
  parameter int NUM_LEGS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  lfp_in_t     item,
  output logic        done,
  output lfp_out_t    result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  `include "legged_foot_placement_top_assert.svh"

  logic [31:0] gait_timing;
  logic [47:0] gains;
  logic [31:0] geom [NUM_LEGS];
  logic        sv;
  lfp_step_t   sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      gait_timing <= 32'h08000800;
      gains <= 48'h014801480148;
      for (int i = 0; i < NUM_LEGS; i++) begin
        geom[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_GAIT) begin
        gait_timing <= cfg_data[31:0];
      end
      if (cfg_index == REG_GAINS) begin
        gains <= cfg_data;
      end
      for (int i = 0; i < NUM_LEGS; i++) begin
        if (cfg_index == 3'(REG_LEG0 + 3'(i))) begin
          geom[i] <= cfg_data[31:0];
        end
      end
    end
  end

  assign busy = 1'b0;

  lfp_step #(.NUM_LEGS(NUM_LEGS)) u_step (
    .clk, .rst,
    .in_valid(start && !busy),
    .in_beat(item),
    .gait_timing, .gains, .geom,
    .out_valid(sv), .out_beat(sb)
  );

  lfp_cordic u_cordic (
    .clk, .rst,
    .in_valid(sv), .in_beat(sb),
    .out_valid(done), .out_beat(result)
  );

  `LFP_ASSERT_NEXT(a_fold, sv, $past(sb.ang) <= ANG_PI2 && $past(sb.ang) >= -ANG_PI2,
    "folded angle out of range")
  `LFP_ASSERT_ALWAYS(a_busy, !busy, "busy raised")
  `LFP_ASSERT_NEXT(a_rst_clear, $past(rst), !done, "result right after reset")
endmodule
